[rtl/uvs_pkg.sv]
// uv sphere vertex generator: shared constants, item types and step functions
// used by the divider cells, the cordic cells and the top level
package uvs_pkg;

  localparam int MAX_RINGS    = 256;
  localparam int MAX_SEGMENTS = 256;
  localparam int ANGLE_STEPS  = 16;
  localparam int DIV_STEPS    = 34;

  localparam logic REG_RING_COUNT    = 1'b0;
  localparam logic REG_SEGMENT_COUNT = 1'b1;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic        has_quad;
    logic [16:0] own;
    logic [8:0]  stride;
  } side_t;

  typedef struct packed {
    logic [9:0]  rem;
    logic [8:0]  dvs;
    logic [33:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic      vld;
    div_lane_t ring;
    div_lane_t seg;
    side_t     side;
  } div_stage_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic [1:0]         quad;
  } cordic_lane_t;

  typedef struct packed {
    logic         vld;
    cordic_lane_t th;
    cordic_lane_t ph;
    logic [16:0]  tex_u;
    logic [16:0]  tex_v;
    side_t        side;
  } cordic_stage_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } cs_t;

  function automatic logic [8:0] clamp_count(logic [8:0] v, logic [8:0] max);
    logic [8:0] r;
    if (v == 9'd0) r = 9'd1;
    else if (v > max) r = max;
    else r = v;
    return r;
  endfunction

  // one restoring step, remainder shifted up for the next bit
  function automatic div_lane_t div_step(div_lane_t a);
    div_lane_t  b;
    logic       ge;
    logic [9:0] t;
    ge    = a.rem >= {1'b0, a.dvs};
    t     = ge ? a.rem - {1'b0, a.dvs} : a.rem;
    b.rem = {t[8:0], 1'b0};
    b.dvs = a.dvs;
    b.quo = {a.quo[32:0], ge};
    return b;
  endfunction

  // fold phase to nearest quarter turn, residue seeds the rotation
  function automatic cordic_lane_t fold_phase(logic [31:0] phase);
    cordic_lane_t b;
    logic [31:0]  sh;
    logic [31:0]  rr;
    sh     = phase + 32'h2000_0000;
    rr     = phase - {sh[31:30], 30'd0};
    b.x    = CORDIC_GAIN;
    b.y    = '0;
    b.z    = $signed({rr[31], rr});
    b.quad = sh[31:30];
    return b;
  endfunction

  function automatic cordic_lane_t cordic_step(cordic_lane_t a, logic [4:0] step);
    cordic_lane_t       b;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [32:0] at;
    dx = $signed(a.y) >>> step;
    dy = $signed(a.x) >>> step;
    at = $signed({1'b0, ATAN_TURNS[step]});
    if (!a.z[32]) begin
      b.x = a.x - dx;
      b.y = a.y + dy;
      b.z = a.z - at;
    end else begin
      b.x = a.x + dx;
      b.y = a.y - dy;
      b.z = a.z + at;
    end
    b.quad = a.quad;
    return b;
  endfunction

  function automatic cs_t quad_rotate(cordic_lane_t a);
    cs_t                r;
    logic signed [33:0] nx;
    logic signed [33:0] ny;
    nx = -a.x;
    ny = -a.y;
    case (a.quad)
      QUAD_0: begin r.c = a.x[31:0]; r.s = a.y[31:0]; end
      QUAD_1: begin r.c = ny[31:0];  r.s = a.x[31:0]; end
      QUAD_2: begin r.c = nx[31:0];  r.s = ny[31:0];  end
      default: begin r.c = a.y[31:0]; r.s = nx[31:0]; end
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_pos(logic signed [17:0] v);
    logic signed [15:0] r;
    if (v < -18'sd16384) r = -16'sd16384;
    else if (v > 18'sd16384) r = 16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

endpackage

[rtl/uvs_div_cell.sv]
// one cell of the phase divider chain: one quotient bit for ring and segment
// depends on uvs_pkg
module uvs_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  uvs_pkg::div_stage_t stage_i,
  output uvs_pkg::div_stage_t stage_o
);

  logic               vld_q;
  uvs_pkg::div_lane_t ring_q;
  uvs_pkg::div_lane_t seg_q;
  uvs_pkg::side_t     side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= stage_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ring_q <= uvs_pkg::div_step(stage_i.ring);
      seg_q  <= uvs_pkg::div_step(stage_i.seg);
      side_q <= stage_i.side;
    end
  end

  assign stage_o.vld  = vld_q;
  assign stage_o.ring = ring_q;
  assign stage_o.seg  = seg_q;
  assign stage_o.side = side_q;

endmodule

[rtl/uvs_cordic_cell.sv]
// one cell of the cordic chain: one rotation step for latitude and longitude
// depends on uvs_pkg
module uvs_cordic_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [4:0]             step_i,
  input  uvs_pkg::cordic_stage_t stage_i,
  output uvs_pkg::cordic_stage_t stage_o
);

  logic                  vld_q;
  uvs_pkg::cordic_lane_t th_q;
  uvs_pkg::cordic_lane_t ph_q;
  logic [16:0]           tex_u_q;
  logic [16:0]           tex_v_q;
  uvs_pkg::side_t        side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= stage_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      th_q    <= uvs_pkg::cordic_step(stage_i.th, step_i);
      ph_q    <= uvs_pkg::cordic_step(stage_i.ph, step_i);
      tex_u_q <= stage_i.tex_u;
      tex_v_q <= stage_i.tex_v;
      side_q  <= stage_i.side;
    end
  end

  assign stage_o.vld   = vld_q;
  assign stage_o.th    = th_q;
  assign stage_o.ph    = ph_q;
  assign stage_o.tex_u = tex_u_q;
  assign stage_o.tex_v = tex_v_q;
  assign stage_o.side  = side_q;

endmodule

[rtl/uv_sphere_vertex_generator_unit.sv]
// uv sphere vertex generator top level: input stage, divider and cordic
// chains, multiply stage, output register with skid; depends on uvs_pkg
//
// Takes one grid point (ring, segment) per cycle while stall_o is low and
// returns its vertex position (Q2.14, radius one), texture pair (Q1.16) and,
// when the point opens a quad, the six triangle indices. A new item is
// accepted every cycle that stall_o is low; the path is 34 divider cells (one
// quotient bit each), one fold stage, 16 cordic cells (one rotation each), one
// multiply stage and the output register. Two result slots (output register
// plus skid) let stall_o come from a register. Counts are set through the APB
// port at 0x0 and 0x4 and must only change while no item is in flight.
module uv_sphere_vertex_generator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [8:0]         ring_index_i,
  input  logic [8:0]         segment_index_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic               has_quad_o,
  output logic [16:0]        tri_a0_o,
  output logic [16:0]        tri_a1_o,
  output logic [16:0]        tri_a2_o,
  output logic [16:0]        tri_b0_o,
  output logic [16:0]        tri_b1_o,
  output logic [16:0]        tri_b2_o
);

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               has_quad;
    logic [16:0]        tri_a0;
    logic [16:0]        tri_a1;
    logic [16:0]        tri_a2;
    logic [16:0]        tri_b0;
    logic [16:0]        tri_b1;
    logic [16:0]        tri_b2;
  } res_t;

  // configuration
  logic [8:0] ring_count_q;
  logic [8:0] segment_count_q;
  logic       cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_count_q    <= 9'd16;
      segment_count_q <= 9'd32;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        uvs_pkg::REG_RING_COUNT:    ring_count_q    <= pwdata[8:0];
        uvs_pkg::REG_SEGMENT_COUNT: segment_count_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      uvs_pkg::REG_RING_COUNT:    prdata = {23'd0, ring_count_q};
      uvs_pkg::REG_SEGMENT_COUNT: prdata = {23'd0, segment_count_q};
      default:                    prdata = '0;
    endcase
  end

  // flow control: the whole chain moves unless the skid slot is occupied
  logic en;
  logic skid_vld_q;

  assign en      = ~skid_vld_q;
  assign stall_o = skid_vld_q;

  // input stage
  logic [8:0]          rings;
  logic [8:0]          segs;
  logic [8:0]          r_sat;
  logic [8:0]          s_sat;
  logic [8:0]          stride;
  logic [17:0]         own_full;
  uvs_pkg::div_stage_t div_chain [uvs_pkg::DIV_STEPS+1];

  always_comb begin
    rings    = uvs_pkg::clamp_count(ring_count_q, 9'(uvs_pkg::MAX_RINGS));
    segs     = uvs_pkg::clamp_count(segment_count_q, 9'(uvs_pkg::MAX_SEGMENTS));
    r_sat    = (ring_index_i > rings) ? rings : ring_index_i;
    s_sat    = (segment_index_i > segs) ? segs : segment_index_i;
    stride   = segs + 9'd1;
    own_full = r_sat * stride + {9'd0, s_sat};

    div_chain[0].vld           = valid_i & en;
    div_chain[0].ring.rem      = {1'b0, r_sat};
    div_chain[0].ring.dvs      = rings;
    div_chain[0].ring.quo      = '0;
    div_chain[0].seg.rem       = {1'b0, s_sat};
    div_chain[0].seg.dvs       = segs;
    div_chain[0].seg.quo       = '0;
    div_chain[0].side.has_quad = (r_sat < rings) && (s_sat < segs);
    div_chain[0].side.own      = own_full[16:0];
    div_chain[0].side.stride   = stride;
  end

  for (genvar k = 0; k < uvs_pkg::DIV_STEPS; k++) begin : g_div
    uvs_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (div_chain[k]),
      .stage_o (div_chain[k+1])
    );
  end

  // quotients are r*2^33/rings and s*2^33/segs; round and fold to phases
  uvs_pkg::div_stage_t   div_out;
  logic [33:0]           pt_sum;
  logic [34:0]           pp_sum;
  logic [18:0]           tv_sum;
  logic [18:0]           tu_sum;
  logic [31:0]           pp;
  uvs_pkg::cordic_stage_t cordic_chain [uvs_pkg::ANGLE_STEPS+1];
  logic                  prep_vld_q;
  uvs_pkg::cordic_lane_t prep_th_q;
  uvs_pkg::cordic_lane_t prep_ph_q;
  logic [16:0]           prep_tex_u_q;
  logic [16:0]           prep_tex_v_q;
  uvs_pkg::side_t        prep_side_q;

  always_comb begin
    div_out = div_chain[uvs_pkg::DIV_STEPS];
    pt_sum  = {1'b0, div_out.ring.quo[33:1]} + 34'd1;
    pp_sum  = {1'b0, div_out.seg.quo} + 35'd1;
    tv_sum  = {1'b0, div_out.ring.quo[33:16]} + 19'd1;
    tu_sum  = {1'b0, div_out.seg.quo[33:16]} + 19'd1;
    pp      = -pp_sum[32:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
    end else if (en) begin
      prep_vld_q <= div_out.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_th_q    <= uvs_pkg::fold_phase(pt_sum[32:1]);
      prep_ph_q    <= uvs_pkg::fold_phase(pp);
      prep_tex_u_q <= tu_sum[17:1];
      prep_tex_v_q <= tv_sum[17:1];
      prep_side_q  <= div_out.side;
    end
  end

  assign cordic_chain[0].vld   = prep_vld_q;
  assign cordic_chain[0].th    = prep_th_q;
  assign cordic_chain[0].ph    = prep_ph_q;
  assign cordic_chain[0].tex_u = prep_tex_u_q;
  assign cordic_chain[0].tex_v = prep_tex_v_q;
  assign cordic_chain[0].side  = prep_side_q;

  for (genvar k = 0; k < uvs_pkg::ANGLE_STEPS; k++) begin : g_cordic
    uvs_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .step_i  (5'(k)),
      .stage_i (cordic_chain[k]),
      .stage_o (cordic_chain[k+1])
    );
  end

  // quadrant correction and products
  uvs_pkg::cordic_stage_t cor_out;
  uvs_pkg::cs_t           th_cs;
  uvs_pkg::cs_t           ph_cs;
  logic                   mul_vld_q;
  logic signed [63:0]     prod_x_q;
  logic signed [63:0]     prod_z_q;
  logic signed [31:0]     ct_q;
  logic [16:0]            mul_tex_u_q;
  logic [16:0]            mul_tex_v_q;
  uvs_pkg::side_t         mul_side_q;

  always_comb begin
    cor_out = cordic_chain[uvs_pkg::ANGLE_STEPS];
    th_cs   = uvs_pkg::quad_rotate(cor_out.th);
    ph_cs   = uvs_pkg::quad_rotate(cor_out.ph);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (en) begin
      mul_vld_q <= cor_out.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_x_q    <= ph_cs.c * th_cs.s;
      prod_z_q    <= ph_cs.s * th_cs.s;
      ct_q        <= th_cs.c;
      mul_tex_u_q <= cor_out.tex_u;
      mul_tex_v_q <= cor_out.tex_v;
      mul_side_q  <= cor_out.side;
    end
  end

  // rounding, clamping and triangle indices
  logic signed [63:0] rx;
  logic signed [63:0] rz;
  logic signed [32:0] ry;
  logic [16:0]        next_idx;
  logic [16:0]        below_idx;
  logic [16:0]        below_next_idx;
  res_t               res;

  always_comb begin
    rx             = prod_x_q + 64'sh0000_2000_0000_0000;
    rz             = prod_z_q + 64'sh0000_2000_0000_0000;
    ry             = {ct_q[31], ct_q} + 33'sd32768;
    next_idx       = mul_side_q.own + 17'd1;
    below_idx      = mul_side_q.own + {8'd0, mul_side_q.stride};
    below_next_idx = below_idx + 17'd1;

    res.pos_x    = uvs_pkg::clamp_pos(rx[63:46]);
    res.pos_y    = uvs_pkg::clamp_pos({ry[32], ry[32:16]});
    res.pos_z    = uvs_pkg::clamp_pos(rz[63:46]);
    res.tex_u    = mul_tex_u_q;
    res.tex_v    = mul_tex_v_q;
    res.has_quad = mul_side_q.has_quad;
    if (mul_side_q.has_quad) begin
      res.tri_a0 = below_idx;
      res.tri_a1 = next_idx;
      res.tri_a2 = mul_side_q.own;
      res.tri_b0 = below_idx;
      res.tri_b1 = below_next_idx;
      res.tri_b2 = next_idx;
    end else begin
      res.tri_a0 = '0;
      res.tri_a1 = '0;
      res.tri_a2 = '0;
      res.tri_b0 = '0;
      res.tri_b1 = '0;
      res.tri_b2 = '0;
    end
  end

  // output register and skid slot
  logic out_vld_q;
  res_t out_q;
  res_t skid_q;
  logic out_take;
  logic incoming;

  assign out_take = out_vld_q & ~stall_i;
  assign incoming = mul_vld_q & en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || out_take) begin
      out_vld_q <= incoming;
    end else if (incoming) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || out_take) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign valid_o    = out_vld_q;
  assign pos_x_o    = out_q.pos_x;
  assign pos_y_o    = out_q.pos_y;
  assign pos_z_o    = out_q.pos_z;
  assign tex_u_o    = out_q.tex_u;
  assign tex_v_o    = out_q.tex_v;
  assign has_quad_o = out_q.has_quad;
  assign tri_a0_o   = out_q.tri_a0;
  assign tri_a1_o   = out_q.tri_a1;
  assign tri_a2_o   = out_q.tri_a2;
  assign tri_b0_o   = out_q.tri_b0;
  assign tri_b1_o   = out_q.tri_b1;
  assign tri_b2_o   = out_q.tri_b2;

endmodule
